// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the envelope RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle envelope check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle envelope check failed");

`endif

// ===== rtl/core/lae_pkg.sv =====
// Types, constants and microcode table of the linear ADSR envelope generator.
package lae_pkg;

  localparam int LVL_W  = 17;
  localparam int TIME_W = 26;
  localparam int DT_W   = 20;
  localparam int NUM_W  = LVL_W + DT_W;
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam int STEP_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [LVL_W-1:0] FULL_SCALE = LVL_W'(65536);

  // request codes
  localparam logic [1:0] REQ_TICK     = 2'd0;
  localparam logic [1:0] REQ_NOTE_ON  = 2'd1;
  localparam logic [1:0] REQ_NOTE_OFF = 2'd2;
  localparam logic [1:0] REQ_RESET    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd3;

  // reported phase codes
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_ATTACK  = 3'd1;
  localparam logic [2:0] PH_DECAY   = 3'd2;
  localparam logic [2:0] PH_SUSTAIN = 3'd3;
  localparam logic [2:0] PH_RELEASE = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_ATTACK  = 5'b00010,
    ST_DECAY   = 5'b00100,
    ST_SUSTAIN = 5'b01000,
    ST_RELEASE = 5'b10000
  } stage_t;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [DT_W-1:0] elapsed_us;
  } lae_in_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [2:0]       phase;
    logic             active;
  } lae_out_t;

  typedef struct packed {
    logic load;
    logic step;
  } lae_div_ctrl_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_TAKE,
    OP_APPLY_PLAIN,
    OP_LOAD,
    OP_DIV,
    OP_APPLY_DIV,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_NEED_DIV,
    C_DIV_MORE,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  // program steps
  localparam logic [STEP_W-1:0] STEP_TAKE     = 3'd0;
  localparam logic [STEP_W-1:0] STEP_DISPATCH = 3'd1;
  localparam logic [STEP_W-1:0] STEP_PLAIN    = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LOAD     = 3'd3;
  localparam logic [STEP_W-1:0] STEP_DIV      = 3'd4;
  localparam logic [STEP_W-1:0] STEP_APPLY    = 3'd5;
  localparam logic [STEP_W-1:0] STEP_SPARE    = 3'd6;
  localparam logic [STEP_W-1:0] STEP_EMIT     = 3'd7;

  // Program ROM; the step after STEP_EMIT wraps to STEP_TAKE.
  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t cw;
    cw = '{op: OP_NONE, cond: C_ALWAYS, target: STEP_TAKE};
    unique case (step)
      STEP_TAKE:     cw = '{op: OP_TAKE,        cond: C_NO_INPUT, target: STEP_TAKE};
      STEP_DISPATCH: cw = '{op: OP_NONE,        cond: C_NEED_DIV, target: STEP_LOAD};
      STEP_PLAIN:    cw = '{op: OP_APPLY_PLAIN, cond: C_ALWAYS,   target: STEP_EMIT};
      STEP_LOAD:     cw = '{op: OP_LOAD,        cond: C_NEVER,    target: STEP_TAKE};
      STEP_DIV:      cw = '{op: OP_DIV,         cond: C_DIV_MORE, target: STEP_DIV};
      STEP_APPLY:    cw = '{op: OP_APPLY_DIV,   cond: C_ALWAYS,   target: STEP_EMIT};
      STEP_EMIT:     cw = '{op: OP_EMIT,        cond: C_OUT_FULL, target: STEP_EMIT};
      default:       cw = '{op: OP_NONE,        cond: C_ALWAYS,   target: STEP_TAKE};
    endcase
    return cw;
  endfunction

  function automatic logic [2:0] phase_code(input stage_t st);
    logic [2:0] ph;
    ph = PH_IDLE;
    unique case (st)
      ST_IDLE:    ph = PH_IDLE;
      ST_ATTACK:  ph = PH_ATTACK;
      ST_DECAY:   ph = PH_DECAY;
      ST_SUSTAIN: ph = PH_SUSTAIN;
      ST_RELEASE: ph = PH_RELEASE;
      default:    ph = PH_IDLE;
    endcase
    return ph;
  endfunction

endpackage

// ===== rtl/core/lae_div.sv =====
// Restoring divider, one quotient bit per step, driven by the microcode.
module lae_div (
  input  logic                         clk,
  input  logic                         rst,
  input  lae_pkg::lae_div_ctrl_t       ctrl,
  input  logic [lae_pkg::NUM_W-1:0]    numer,
  input  logic [lae_pkg::TIME_W-1:0]   denom,
  output logic [lae_pkg::NUM_W-1:0]    quot,
  output logic                         more
);

  localparam int NW = lae_pkg::NUM_W;
  localparam int DW = lae_pkg::TIME_W;
  localparam int CW = lae_pkg::CNT_W;

  logic [NW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] den;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem, quo[NW-1]};
  assign diff  = trial - {1'b0, den};
  assign quot  = quo;
  assign more  = (cnt != CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.load) begin
      cnt <= CW'(NW);
    end else if (ctrl.step) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      quo <= numer;
      rem <= '0;
      den <= denom;
    end else if (ctrl.step) begin
      // keep the difference when the trial remainder covers the divisor
      if (!diff[DW]) begin
        rem <= diff[DW-1:0];
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= trial[DW-1:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/core/linear_adsr_envelope.sv =====
// Linear ADSR envelope generator: microcode sequencer, datapath and ports.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall    in_data   (lae_in_t)
//   out      output     out_valid/out_stall  out_data  (lae_out_t)
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item at a time. Requests that need no division pass dispatch and plain
// apply, then reach the output register in the emit step; ticks in attack,
// decay or release with a nonzero stage time pass dispatch, load, the 37 steps
// of the divider and apply. A new item is taken only after emit finishes.
// rst is synchronous: stage idle, level and release start zero, registers at
// their reset values. The output register holds a result under out_stall
// while the next item is accepted; the sequencer waits in its emit step
// only if a second result finds the output register still full.
module linear_adsr_envelope (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lae_pkg::lae_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lae_pkg::lae_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lae_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lae_pkg::TIME_W-1:0]      cfg_data
);

  `include "assert_macros.svh"

  localparam int LW    = lae_pkg::LVL_W;
  localparam int TW    = lae_pkg::TIME_W;
  localparam int NW    = lae_pkg::NUM_W;
  localparam int SUM_W = lae_pkg::NUM_W + 1;

  // configuration
  logic [TW-1:0] attack_time;
  logic [TW-1:0] decay_time;
  logic [LW-1:0] sus_level;
  logic [TW-1:0] release_time;

  // envelope state
  lae_pkg::stage_t stage, stage_next;
  logic [LW-1:0]   level, level_next;
  logic [LW-1:0]   rel_from, rel_from_next;

  // sequencer
  logic [lae_pkg::STEP_W-1:0] pc, pc_next;
  lae_pkg::ctrl_word_t        cw;
  logic                       jump;

  lae_pkg::lae_in_t item;
  logic [LW-1:0]    sus_eff;
  logic             need_div;
  logic             out_full;

  // attack completion values
  lae_pkg::stage_t  done_stage;
  logic [LW-1:0]    done_level;

  // datapath
  logic [LW-1:0]          mul_a;
  logic [TW-1:0]          den_sel;
  logic [NW-1:0]          prod;
  logic [NW-1:0]          quot;
  logic                   div_more;
  lae_pkg::lae_div_ctrl_t div_ctrl;
  logic [SUM_W-1:0]       att_sum;
  logic [SUM_W-1:0]       dec_sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_time   <= '0;
      decay_time    <= '0;
      sus_level     <= lae_pkg::FULL_SCALE;
      release_time  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lae_pkg::CFG_ATTACK:  attack_time   <= cfg_data;
        lae_pkg::CFG_DECAY:   decay_time    <= cfg_data;
        lae_pkg::CFG_SUSTAIN: sus_level     <= cfg_data[LW-1:0];
        lae_pkg::CFG_RELEASE: release_time  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sus_eff = (sus_level > lae_pkg::FULL_SCALE) ? lae_pkg::FULL_SCALE
                                                     : sus_level;

  // ---------------- sequencer ----------------
  assign cw       = lae_pkg::ucode(pc);
  assign in_stall = (cw.op != lae_pkg::OP_TAKE);
  assign out_full = out_valid && out_stall;

  assign need_div = (item.req_type == lae_pkg::REQ_TICK) &&
                    (((stage == lae_pkg::ST_ATTACK)  && (attack_time  != '0)) ||
                     ((stage == lae_pkg::ST_DECAY)   && (decay_time   != '0)) ||
                     ((stage == lae_pkg::ST_RELEASE) && (release_time != '0)));

  always_comb begin
    case (cw.cond)
      lae_pkg::C_NEVER:    jump = 1'b0;
      lae_pkg::C_ALWAYS:   jump = 1'b1;
      lae_pkg::C_NO_INPUT: jump = !in_valid;
      lae_pkg::C_NEED_DIV: jump = need_div;
      lae_pkg::C_DIV_MORE: jump = div_more;
      lae_pkg::C_OUT_FULL: jump = out_full;
      default:             jump = 1'b1;
    endcase
    pc_next = jump ? cw.target : pc + lae_pkg::STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= lae_pkg::STEP_TAKE;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

  // ---------------- datapath ----------------
  always_comb begin
    mul_a   = lae_pkg::FULL_SCALE;
    den_sel = attack_time;
    unique case (stage)
      lae_pkg::ST_DECAY: begin
        mul_a   = lae_pkg::FULL_SCALE - sus_eff;
        den_sel = decay_time;
      end
      lae_pkg::ST_RELEASE: begin
        mul_a   = rel_from;
        den_sel = release_time;
      end
      default: begin
        mul_a   = lae_pkg::FULL_SCALE;
        den_sel = attack_time;
      end
    endcase
  end

  assign prod = NW'(mul_a) * NW'(item.elapsed_us);

  assign div_ctrl.load = (cw.op == lae_pkg::OP_LOAD);
  assign div_ctrl.step = (cw.op == lae_pkg::OP_DIV);

  lae_div u_div (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (div_ctrl),
    .numer (prod),
    .denom (den_sel),
    .quot  (quot),
    .more  (div_more)
  );

  assign att_sum = SUM_W'(level) + SUM_W'(quot);
  assign dec_sum = SUM_W'(sus_eff) + SUM_W'(quot);

  always_comb begin
    if (decay_time != '0) begin
      done_stage = lae_pkg::ST_DECAY;
      done_level = lae_pkg::FULL_SCALE;
    end else begin
      done_stage = lae_pkg::ST_SUSTAIN;
      done_level = sus_eff;
    end
  end

  always_comb begin
    stage_next    = stage;
    level_next    = level;
    rel_from_next = rel_from;
    case (cw.op)
      lae_pkg::OP_APPLY_PLAIN: begin
        case (item.req_type)
          lae_pkg::REQ_TICK: begin
            unique case (stage)
              lae_pkg::ST_ATTACK: begin
                stage_next = done_stage;
                level_next = done_level;
              end
              lae_pkg::ST_DECAY, lae_pkg::ST_SUSTAIN: begin
                stage_next = lae_pkg::ST_SUSTAIN;
                level_next = sus_eff;
              end
              default: begin
                stage_next    = lae_pkg::ST_IDLE;
                level_next    = '0;
                rel_from_next = '0;
              end
            endcase
          end
          lae_pkg::REQ_NOTE_ON: begin
            if (attack_time == '0) begin
              stage_next = done_stage;
              level_next = done_level;
            end else begin
              stage_next = lae_pkg::ST_ATTACK;
            end
          end
          lae_pkg::REQ_NOTE_OFF: begin
            // ignore while idle or already releasing
            if (stage != lae_pkg::ST_IDLE && stage != lae_pkg::ST_RELEASE) begin
              if (release_time == '0) begin
                stage_next    = lae_pkg::ST_IDLE;
                level_next    = '0;
                rel_from_next = '0;
              end else begin
                stage_next    = lae_pkg::ST_RELEASE;
                rel_from_next = level;
              end
            end
          end
          default: begin
            stage_next    = lae_pkg::ST_IDLE;
            level_next    = '0;
            rel_from_next = '0;
          end
        endcase
      end
      lae_pkg::OP_APPLY_DIV: begin
        unique case (stage)
          lae_pkg::ST_ATTACK: begin
            if (att_sum >= SUM_W'(lae_pkg::FULL_SCALE)) begin
              stage_next = done_stage;
              level_next = done_level;
            end else begin
              level_next = att_sum[LW-1:0];
            end
          end
          lae_pkg::ST_DECAY: begin
            // land on sustain once the drop reaches it
            if (dec_sum >= SUM_W'(level)) begin
              stage_next = lae_pkg::ST_SUSTAIN;
              level_next = sus_eff;
            end else begin
              level_next = level - quot[LW-1:0];
            end
          end
          lae_pkg::ST_RELEASE: begin
            if (SUM_W'(quot) >= SUM_W'(level)) begin
              stage_next    = lae_pkg::ST_IDLE;
              level_next    = '0;
              rel_from_next = '0;
            end else begin
              level_next = level - quot[LW-1:0];
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage    <= lae_pkg::ST_IDLE;
      level    <= '0;
      rel_from <= '0;
    end else begin
      stage    <= stage_next;
      level    <= level_next;
      rel_from <= rel_from_next;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.op == lae_pkg::OP_EMIT && !out_full) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == lae_pkg::OP_EMIT && !out_full) begin
      out_data.level  <= level;
      out_data.phase  <= lae_pkg::phase_code(stage);
      out_data.active <= (stage != lae_pkg::ST_IDLE);
    end
  end

  // ---------------- assertions ----------------
  `ASSERT_NOW(a_idle_clear, stage == lae_pkg::ST_IDLE, level == '0 && rel_from == '0)
  `ASSERT_NOW(a_sustain_level, cw.op == lae_pkg::OP_EMIT && stage == lae_pkg::ST_SUSTAIN, level == sus_eff)
  `ASSERT_NEXT(a_emit_loads, cw.op == lae_pkg::OP_EMIT && !out_full, out_valid)
  `ASSERT_NEXT(a_load_then_div, cw.op == lae_pkg::OP_LOAD, cw.op == lae_pkg::OP_DIV)

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the linear ADSR envelope generator.
`timescale 1ns / 1ps

module testbench;

  typedef longint unsigned u64_t;

  localparam longint FULL_LEVEL  = 65536;
  localparam int     QUIET_LIMIT = 2000;
  localparam int     SETTLE      = 60;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  lae_pkg::lae_in_t              in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  lae_pkg::lae_out_t             out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [lae_pkg::CFG_IDX_W-1:0] cfg_index = lae_pkg::CFG_ATTACK;
  logic [lae_pkg::TIME_W-1:0]    cfg_data = '0;

  linear_adsr_envelope dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicted envelope state and register copy
  logic [2:0]                 env_stage = lae_pkg::PH_IDLE;
  longint                     env_level = 0;
  longint                     env_rel_from = 0;
  logic [lae_pkg::TIME_W-1:0] atk_us = '0;
  logic [lae_pkg::TIME_W-1:0] dec_us = '0;
  logic [lae_pkg::TIME_W-1:0] rel_us = '0;
  logic [lae_pkg::LVL_W-1:0]  sus_reg = lae_pkg::LVL_W'(65536);

  lae_pkg::lae_out_t expected_results[$];

  bit calm = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int settings_run = 0;
  int stage_hits[5] = '{default: 0};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_envelope();
    env_stage = lae_pkg::PH_IDLE;
    env_level = 0;
    env_rel_from = 0;
  endfunction

  function automatic void finish_attack(input longint sus);
    env_level = FULL_LEVEL;
    if (dec_us != 0) begin
      env_stage = lae_pkg::PH_DECAY;
    end else begin
      env_stage = lae_pkg::PH_SUSTAIN;
      env_level = sus;
    end
  endfunction

  // Advance the envelope by one request and return the level, phase and active flag it reports.
  function automatic lae_pkg::lae_out_t envelope_step(input lae_pkg::lae_in_t req);
    longint            sus;
    u64_t              dt;
    u64_t              headroom;
    lae_pkg::lae_out_t res;
    sus = (sus_reg > FULL_LEVEL) ? FULL_LEVEL : longint'(sus_reg);
    dt = u64_t'(req.elapsed_us);
    headroom = u64_t'(FULL_LEVEL - sus);
    case (req.req_type)
      lae_pkg::REQ_TICK: begin
        case (env_stage)
          lae_pkg::PH_ATTACK: begin
            if (atk_us == 0) begin
              finish_attack(sus);
            end else begin
              env_level += longint'((dt << 16) / atk_us);
              if (env_level >= FULL_LEVEL) finish_attack(sus);
            end
          end
          lae_pkg::PH_DECAY: begin
            if (dec_us == 0) begin
              env_level = sus;
              env_stage = lae_pkg::PH_SUSTAIN;
            end else begin
              env_level -= longint'((headroom * dt) / dec_us);
              if (env_level <= sus) begin
                env_level = sus;
                env_stage = lae_pkg::PH_SUSTAIN;
              end
            end
          end
          lae_pkg::PH_SUSTAIN: env_level = sus;
          lae_pkg::PH_RELEASE: begin
            if (rel_us == 0) begin
              clear_envelope();
            end else begin
              env_level -= longint'((u64_t'(env_rel_from) * dt) / rel_us);
              if (env_level <= 0) clear_envelope();
            end
          end
          default: begin
            env_stage = lae_pkg::PH_IDLE;
            env_level = 0;
          end
        endcase
        if (env_level < 0) env_level = 0;
        if (env_level > FULL_LEVEL) env_level = FULL_LEVEL;
      end
      lae_pkg::REQ_NOTE_ON: begin
        if (atk_us == 0) finish_attack(sus);
        else env_stage = lae_pkg::PH_ATTACK;
      end
      lae_pkg::REQ_NOTE_OFF: begin
        if (env_stage != lae_pkg::PH_IDLE && env_stage != lae_pkg::PH_RELEASE) begin
          env_rel_from = env_level;
          if (rel_us == 0) clear_envelope();
          else env_stage = lae_pkg::PH_RELEASE;
        end
      end
      default: clear_envelope();
    endcase
    res.level = env_level[lae_pkg::LVL_W-1:0];
    res.phase = env_stage;
    res.active = (env_stage != lae_pkg::PH_IDLE);
    return res;
  endfunction

  // Send one request, after a random gap unless calm is set, and record its expected result.
  task automatic send_request(input logic [1:0] kind,
                              input logic [lae_pkg::DT_W-1:0] dt);
    int               gap;
    lae_pkg::lae_in_t req;
    gap = calm ? 0 : $urandom_range(0, 7);
    req.req_type = kind;
    req.elapsed_us = dt;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(envelope_step(req));
    items_sent++;
  endtask

  // Hold off new requests until every expected result has come back.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic [lae_pkg::CFG_IDX_W-1:0] idx,
                                input logic [lae_pkg::TIME_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lae_pkg::CFG_ATTACK:  atk_us = value;
      lae_pkg::CFG_DECAY:   dec_us = value;
      lae_pkg::CFG_SUSTAIN: sus_reg = value[lae_pkg::LVL_W-1:0];
      default:              rel_us = value;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input logic [lae_pkg::TIME_W-1:0] atk,
                           input logic [lae_pkg::TIME_W-1:0] dec,
                           input logic [lae_pkg::TIME_W-1:0] sus,
                           input logic [lae_pkg::TIME_W-1:0] rel);
    write_register(lae_pkg::CFG_ATTACK, atk);
    write_register(lae_pkg::CFG_DECAY, dec);
    write_register(lae_pkg::CFG_SUSTAIN, sus);
    write_register(lae_pkg::CFG_RELEASE, rel);
    settings_run++;
  endtask

  function automatic logic [lae_pkg::TIME_W-1:0] pick_time();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return lae_pkg::TIME_W'($urandom_range(1, 100));
      3:       return lae_pkg::TIME_W'($urandom_range(1, 50000));
      4:       return lae_pkg::TIME_W'($urandom_range(1, 2000000));
      default: return lae_pkg::TIME_W'($urandom);
    endcase
  endfunction

  function automatic logic [lae_pkg::TIME_W-1:0] pick_sustain();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return lae_pkg::TIME_W'(65536);
      2:       return lae_pkg::TIME_W'($urandom_range(65537, 131071));
      3:       return lae_pkg::TIME_W'($urandom_range(0, 65536));
      default: return lae_pkg::TIME_W'($urandom);
    endcase
  endfunction

  function automatic logic [lae_pkg::DT_W-1:0] pick_elapsed(input int span);
    if ($urandom_range(0, 3) == 0) return lae_pkg::DT_W'($urandom);
    return lae_pkg::DT_W'($urandom_range(0, span));
  endfunction

  task automatic test_reset_defaults();
    send_request(lae_pkg::REQ_TICK, '0);
    send_request(lae_pkg::REQ_TICK, '1);
    send_request(lae_pkg::REQ_NOTE_OFF, lae_pkg::DT_W'(20'h5A5A5));
    send_request(lae_pkg::REQ_NOTE_ON, '0);
    send_request(lae_pkg::REQ_TICK, lae_pkg::DT_W'(20'h12345));
    send_request(lae_pkg::REQ_NOTE_OFF, '0);
    send_request(lae_pkg::REQ_RESET, '1);
  endtask

  task automatic test_stage_ramps();
    wait_for_results();
    write_all(lae_pkg::TIME_W'(1000), lae_pkg::TIME_W'(2000), lae_pkg::TIME_W'(16384),
              lae_pkg::TIME_W'(4000));
    send_request(lae_pkg::REQ_NOTE_ON, '0);
    send_request(lae_pkg::REQ_TICK, lae_pkg::DT_W'(300));
    send_request(lae_pkg::REQ_TICK, '1);
    send_request(lae_pkg::REQ_TICK, lae_pkg::DT_W'(700));
    send_request(lae_pkg::REQ_TICK, '1);
    // retrigger from sustain keeps the level
    send_request(lae_pkg::REQ_NOTE_ON, '0);
    send_request(lae_pkg::REQ_NOTE_OFF, '0);
    send_request(lae_pkg::REQ_NOTE_OFF, '0);
    send_request(lae_pkg::REQ_TICK, lae_pkg::DT_W'(1000));
    send_request(lae_pkg::REQ_TICK, '1);
  endtask

  task automatic test_zero_stage_times();
    send_request(lae_pkg::REQ_NOTE_ON, '0);
    send_request(lae_pkg::REQ_TICK, lae_pkg::DT_W'(100));
    wait_for_results();
    write_register(lae_pkg::CFG_ATTACK, '0);
    send_request(lae_pkg::REQ_TICK, lae_pkg::DT_W'(5));
    wait_for_results();
    write_register(lae_pkg::CFG_DECAY, '0);
    send_request(lae_pkg::REQ_TICK, lae_pkg::DT_W'(5));
    send_request(lae_pkg::REQ_NOTE_OFF, '0);
    wait_for_results();
    write_register(lae_pkg::CFG_RELEASE, '0);
    send_request(lae_pkg::REQ_TICK, lae_pkg::DT_W'(5));
  endtask

  task automatic test_register_extremes();
    wait_for_results();
    write_all('1, '1, lae_pkg::TIME_W'(17'h1FFFF), '1);
    send_request(lae_pkg::REQ_NOTE_ON, '0);
    send_request(lae_pkg::REQ_TICK, '1);
    send_request(lae_pkg::REQ_RESET, '0);
  endtask

  task automatic test_random_traffic();
    int                         first;
    int                         span;
    logic [lae_pkg::TIME_W-1:0] longest;
    for (int setting = 0; setting < 12; setting++) begin
      wait_for_results();
      calm = (setting % 4 == 3);
      if (setting == 0) write_all('0, '0, '0, '0);
      else if (setting == 1) write_all(lae_pkg::TIME_W'(1), lae_pkg::TIME_W'(1),
                                       lae_pkg::TIME_W'(65536), lae_pkg::TIME_W'(1));
      else write_all(pick_time(), pick_time(), pick_sustain(), pick_time());
      longest = atk_us;
      if (dec_us > longest) longest = dec_us;
      if (rel_us > longest) longest = rel_us;
      span = (longest / 4 > 1048575) ? 1048575 : int'(longest / 4);
      if (span < 16) span = 16;
      first = items_sent;
      while (items_sent - first < 102) begin
        if ($urandom_range(0, 4) == 0) begin
          send_request(2'($urandom_range(0, 3)), lae_pkg::DT_W'($urandom));
        end else begin
          // one note: press, ramp, maybe retrigger, release, ramp down
          send_request(lae_pkg::REQ_NOTE_ON, lae_pkg::DT_W'($urandom));
          repeat ($urandom_range(1, 16)) send_request(lae_pkg::REQ_TICK, pick_elapsed(span));
          if ($urandom_range(0, 3) == 0) begin
            send_request(lae_pkg::REQ_NOTE_ON, lae_pkg::DT_W'($urandom));
            repeat ($urandom_range(0, 6)) send_request(lae_pkg::REQ_TICK, pick_elapsed(span));
          end
          send_request(lae_pkg::REQ_NOTE_OFF, lae_pkg::DT_W'($urandom));
          repeat ($urandom_range(0, 12)) send_request(lae_pkg::REQ_TICK, pick_elapsed(span));
        end
        if ($urandom_range(0, 39) == 0) wait_for_results();
      end
    end
    calm = 1'b0;
  endtask

  // drain results with random backpressure and compare field by field
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    lae_pkg::lae_out_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      stall_left = calm ? 0 : $urandom_range(0, 7);
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item: level %0d phase %0d active %0b",
                 $time, out_data.level, out_data.phase, out_data.active);
      end else begin
        want = expected_results.pop_front();
        if (want.phase < 5) stage_hits[want.phase]++;
        if (out_data.level !== want.level) begin
          mismatches++;
          $display("%0t: level expected %0d actual %0d", $time, want.level, out_data.level);
        end
        if (out_data.phase !== want.phase) begin
          mismatches++;
          $display("%0t: phase expected %0d actual %0d", $time, want.phase, out_data.phase);
        end
        if (out_data.active !== want.active) begin
          mismatches++;
          $display("%0t: active expected %0b actual %0b", $time, want.active,
                   out_data.active);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_stage_ramps();
    test_zero_stage_times();
    test_register_extremes();
    test_random_traffic();
    wait_for_results();
    repeat (SETTLE) @(posedge clk);
    if (expected_results.size() != 0) mismatches++;
    $display("Sent %0d requests, checked %0d results, %0d register writes, %0d settings.",
             items_sent, results_seen, reg_writes, settings_run);
    $display("Results by stage: idle %0d attack %0d decay %0d sustain %0d release %0d",
             stage_hits[0], stage_hits[1], stage_hits[2], stage_hits[3], stage_hits[4]);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== linear_adsr_envelope.f =====
+incdir+rtl/core
rtl/core/lae_pkg.sv
rtl/core/lae_div.sv
rtl/core/linear_adsr_envelope.sv
test/testbench.sv
